FILE: rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescape block.
package jsu_pkg;

  // Decoder mode: outside a string, inside, after a backslash, inside \u.
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX0 = 3'd3,
    MODE_HEX1 = 3'd4,
    MODE_HEX2 = 3'd5,
    MODE_HEX3 = 3'd6
  } jsu_mode_t;

  typedef enum logic [2:0] {
    ST_BYTE          = 3'd0,
    ST_END           = 3'd1,
    ST_EXPECT_QUOTE  = 3'd2,
    ST_BAD_ESCAPE    = 3'd3,
    ST_BAD_HEX       = 3'd4,
    ST_UNTERM_STRING = 3'd5,
    ST_UNTERM_ESCAPE = 3'd6,
    ST_SHORT_U       = 3'd7
  } jsu_status_t;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned IDX_W   = $clog2(MAX_RES);
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } jsu_in_t;

  typedef struct packed {
    jsu_status_t status;
    logic [7:0]  out_byte;
    logic        last;
  } jsu_out_t;

  // Everything one source byte produces: next state plus its result words.
  typedef struct packed {
    jsu_mode_t                  mode;
    logic [15:0]                hex;
    logic [CNT_W-1:0]           cnt;
    jsu_out_t [MAX_RES-1:0]     res;
  } jsu_dec_t;

endpackage

FILE: rtl/jsu_decode.sv
// Combinational decode of one source byte against the current mode.
module jsu_decode
  import jsu_pkg::*;
(
  input  jsu_mode_t   mode,
  input  logic [15:0] hex,
  input  jsu_in_t     in_word,
  output jsu_dec_t    dec
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  logic [7:0]      c;
  logic            eoi;
  logic            is_hex;
  logic [3:0]      hv;
  logic [15:0]     code;
  logic [7:0]      bytes [3];
  logic [1:0]      nb;
  logic            has_term;
  jsu_status_t     term;
  logic            decoded;
  logic            simple;
  logic [7:0]      simple_b;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    c   = in_word.data_byte;
    eoi = in_word.end_of_input;

    is_hex = 1'b1;
    hv     = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      hv = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hv = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end

    simple   = 1'b1;
    simple_b = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: simple_b = c;
      8'h62: simple_b = 8'h08;
      8'h66: simple_b = 8'h0C;
      8'h6E: simple_b = 8'h0A;
      8'h72: simple_b = 8'h0D;
      8'h74: simple_b = 8'h09;
      default: simple = 1'b0;
    endcase

    code     = {hex[11:0], hv};
    bytes[0] = c;
    bytes[1] = 8'h00;
    bytes[2] = 8'h00;
    nb       = 2'd0;
    has_term = 1'b0;
    term     = ST_END;
    decoded  = 1'b0;
    dec.mode = mode;
    dec.hex  = hex;

    case (mode)
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          has_term = 1'b1;
          term     = ST_END;
          dec.mode = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
          dec.mode = MODE_ESC;
          if (eoi) begin
            has_term = 1'b1;
            term     = ST_UNTERM_ESCAPE;
            dec.mode = MODE_IDLE;
          end
        end else begin
          nb      = 2'd1;
          decoded = 1'b1;
        end
      end
      MODE_ESC: begin
        if (simple) begin
          bytes[0] = simple_b;
          nb       = 2'd1;
          decoded  = 1'b1;
          dec.mode = MODE_STR;
        end else if (c == CH_U) begin
          dec.hex  = 16'h0000;
          dec.mode = MODE_HEX0;
          if (eoi) begin
            has_term = 1'b1;
            term     = ST_SHORT_U;
            dec.mode = MODE_IDLE;
          end
        end else begin
          has_term = 1'b1;
          term     = ST_BAD_ESCAPE;
          dec.mode = MODE_IDLE;
        end
      end
      MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
        if (!is_hex) begin
          has_term = 1'b1;
          term     = ST_BAD_HEX;
          dec.mode = MODE_IDLE;
        end else begin
          dec.hex = code;
          if (mode == MODE_HEX3) begin
            // Encode the code point as UTF-8, one to three bytes.
            if (code < 16'h0080) begin
              bytes[0] = code[7:0];
              nb       = 2'd1;
            end else if (code < 16'h0800) begin
              bytes[0] = {3'b110, code[10:6]};
              bytes[1] = {2'b10, code[5:0]};
              nb       = 2'd2;
            end else begin
              bytes[0] = {4'b1110, code[15:12]};
              bytes[1] = {2'b10, code[11:6]};
              bytes[2] = {2'b10, code[5:0]};
              nb       = 2'd3;
            end
            decoded  = 1'b1;
            dec.mode = MODE_STR;
          end else begin
            case (mode)
              MODE_HEX0: dec.mode = MODE_HEX1;
              MODE_HEX1: dec.mode = MODE_HEX2;
              default:   dec.mode = MODE_HEX3;
            endcase
            if (eoi) begin
              has_term = 1'b1;
              term     = ST_SHORT_U;
              dec.mode = MODE_IDLE;
            end
          end
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          dec.mode = MODE_STR;
          if (eoi) begin
            has_term = 1'b1;
            term     = ST_UNTERM_STRING;
            dec.mode = MODE_IDLE;
          end
        end else begin
          has_term = 1'b1;
          term     = ST_EXPECT_QUOTE;
          dec.mode = MODE_IDLE;
        end
      end
    endcase

    if (decoded && eoi) begin
      has_term = 1'b1;
      term     = ST_UNTERM_STRING;
      dec.mode = MODE_IDLE;
    end

    // Bytes first, then at most one status word; mark the final one.
    cnt     = CNT_W'(nb) + CNT_W'(has_term);
    dec.cnt = cnt;
    for (int i = 0; i < MAX_RES; i++) begin
      dec.res[i].status   = ST_BYTE;
      dec.res[i].out_byte = 8'h00;
      if (i < 3 && CNT_W'(i) < CNT_W'(nb)) begin
        dec.res[i].out_byte = bytes[i];
      end else if (CNT_W'(i) == CNT_W'(nb)) begin
        dec.res[i].status = term;
      end
      dec.res[i].last = (CNT_W'(i + 1) == cnt);
    end
  end

endmodule

FILE: rtl/json_string_unescape.sv
// Top level of the streaming JSON string literal unescaper.
//
// Usage: feed the raw bytes of one string literal, opening quote first, on
// the in_ channel (in_valid/in_ready, word = jsu_in_t). Set end_of_input on
// the last source byte. Decoded bytes and status words leave on the out_
// channel (out_valid/out_ready, word = jsu_out_t); status 0 carries a byte,
// any other status ends the string or reports an error, and last marks the
// final word caused by one input byte.
// Path: an accepted byte waits in the input register, is decoded combinationally
// and is written into the result register, where its first word appears.
// Throughput: one byte per cycle while out_ready is high and each yields at most
// one word; a byte with more words (at most four) holds the result register until its last word leaves.
// Bytes that yield no word (opening quote, backslash, u, early hex digits)
// retire from the input register without touching the result register.
// Reset: returns to idle awaiting an opening quote, clears the collected
// hex digits and empties both registers.
// Stall: while out_ready is low the result word holds; bytes that yield no
// word keep retiring, the next byte with words waits in the input register
// and in_ready drops.
module json_string_unescape
  import jsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  jsu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output jsu_out_t out_data
);

  jsu_mode_t              mode_r;
  logic [15:0]            hex_r;
  jsu_in_t                in_r;
  logic                   in_vld_r, in_vld_nxt;
  jsu_out_t [MAX_RES-1:0] res_r;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   bnd_vld_r, bnd_vld_nxt;

  jsu_dec_t dec;
  logic     out_fire;
  logic     bnd_done;
  logic     bnd_free;
  logic     take;

  jsu_decode u_decode (
    .mode    (mode_r),
    .hex     (hex_r),
    .in_word (in_r),
    .dec     (dec)
  );

  assign out_valid = bnd_vld_r;
  assign out_data  = res_r[idx_r];
  assign out_fire  = out_valid && out_ready;
  assign bnd_done  = out_fire && out_data.last;
  assign bnd_free  = !bnd_vld_r || bnd_done;

  // Retire the held byte when its words fit: no words, or the bundle frees.
  assign take     = in_vld_r && ((dec.cnt == '0) || bnd_free);
  assign in_ready = !in_vld_r || take;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (take) begin
      in_vld_nxt = 1'b0;
    end

    bnd_vld_nxt = bnd_vld_r;
    idx_nxt     = idx_r;
    if (take && dec.cnt != '0) begin
      bnd_vld_nxt = 1'b1;
      idx_nxt     = '0;
    end else if (bnd_done) begin
      bnd_vld_nxt = 1'b0;
      idx_nxt     = '0;
    end else if (out_fire) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hex_r     <= '0;
      in_vld_r  <= 1'b0;
      bnd_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      bnd_vld_r <= bnd_vld_nxt;
      idx_r     <= idx_nxt;
      if (take) begin
        mode_r <= dec.mode;
        hex_r  <= dec.hex;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (take && dec.cnt != '0) begin
      res_r <= dec.res;
    end
  end

`ifndef NO_ASSERTIONS
  // Any status other than a byte closes the words of its input byte.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_BYTE) |-> out_data.last)
    else $error("status word not marked last");

  // Finishing a bundle rewinds the word index.
  a_idx_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    bnd_done |=> (idx_r == '0))
    else $error("word index not rewound after last word");

  // A byte that yields no word always leaves the decoder inside a string.
  a_silent_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (take && dec.cnt == '0) |=> (mode_r != MODE_IDLE))
    else $error("silent byte returned decoder to idle");
`endif

endmodule
